// ===== design/assert_macros.svh =====
// Assertion macros used by the port-level checker of the echo ranger.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== design/uer_pkg.sv =====
// Package with the types and codes of the ultrasonic echo ranger.
`default_nettype none

package uer_pkg;

    // Measurement phase, one-hot.
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_TRIG = 4'b0010,
        PH_WAIT = 4'b0100,
        PH_MEAS = 4'b1000
    } phase_t;

    // Completion status codes.
    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_NO_RESPONSE  = 2'd1;
    localparam logic [1:0] STATUS_OUT_OF_RANGE = 2'd2;

    // Register indexes (byte address = 4 * index).
    localparam logic [1:0] REG_TRIGGER_WIDTH    = 2'd0;
    localparam logic [1:0] REG_RESPONSE_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_UNIT_TICKS       = 2'd2;
    localparam logic [1:0] REG_RANGE_LIMIT      = 2'd3;

    // Register reset values.
    localparam logic [7:0]  TRIGGER_WIDTH_RST    = 8'd20;
    localparam logic [19:0] RESPONSE_TIMEOUT_RST = 20'd1000000;
    localparam logic [7:0]  UNIT_TICKS_RST       = 8'd9;
    localparam logic [15:0] RANGE_LIMIT_RST      = 16'd10000;

    // One result transaction.
    typedef struct packed {
        logic        trig;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [16:0] distance;
    } result_t;

endpackage

`default_nettype wire

// ===== design/ultrasonic_echo_ranger_unit.sv =====
// Results are registered. Throughput: one tick per clock cycle while the skid
// entry is empty; the phase and counter update is combinational, and a
// two-entry output buffer lets ticks keep flowing while one result waits.
// Reset clears the phase, counters and output buffer and loads the register
// defaults (20, 1000000, 9, 10000).
`default_nettype none

module ultrasonic_echo_ranger_unit
    import uer_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Tick channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        start_req,
    input  wire logic        echo,
    // Result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             trig,
    output logic             busy_res,
    output logic             done_res,
    output logic [1:0]       status,
    output logic [16:0]      distance,
    // Register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0]  trigger_width_reg;
    logic [19:0] response_timeout_reg;
    logic [7:0]  unit_ticks_reg;
    logic [15:0] range_limit_reg;

    phase_t      phase_reg, phase_next;
    logic [19:0] tick_count_reg, tick_count_next;
    logic [7:0]  unit_sub_reg, unit_sub_next;
    logic [15:0] unit_count_reg, unit_count_next;

    result_t     res_next;
    result_t     out_reg, skid_reg;
    logic        out_valid_reg, skid_valid_reg;

    logic        in_accept, out_accept, cfg_write;
    logic [1:0]  reg_index;
    logic [19:0] tick_inc;
    logic [7:0]  sub_inc;
    logic [15:0] count_inc;
    logic [17:0] dist_sum;

    // Register access
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_width_reg    <= TRIGGER_WIDTH_RST;
            response_timeout_reg <= RESPONSE_TIMEOUT_RST;
            unit_ticks_reg       <= UNIT_TICKS_RST;
            range_limit_reg      <= RANGE_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_TRIGGER_WIDTH:    trigger_width_reg    <= pwdata[7:0];
                REG_RESPONSE_TIMEOUT: response_timeout_reg <= pwdata[19:0];
                REG_UNIT_TICKS:       unit_ticks_reg       <= pwdata[7:0];
                REG_RANGE_LIMIT:      range_limit_reg      <= pwdata[15:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_TRIGGER_WIDTH:    prdata = {24'd0, trigger_width_reg};
            REG_RESPONSE_TIMEOUT: prdata = {12'd0, response_timeout_reg};
            REG_UNIT_TICKS:       prdata = {24'd0, unit_ticks_reg};
            REG_RANGE_LIMIT:      prdata = {16'd0, range_limit_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // Handshakes
    assign in_stall   = skid_valid_reg;
    assign in_accept  = in_valid & ~skid_valid_reg;
    assign out_accept = out_valid_reg & ~out_stall;

    assign tick_inc  = tick_count_reg + 20'd1;
    assign sub_inc   = unit_sub_reg + 8'd1;
    assign count_inc = unit_count_reg + 16'd1;
    // count * 3, halved by dropping the low bit
    assign dist_sum  = {2'b00, count_inc} + {1'b0, count_inc, 1'b0};

    // Advance the measurement by one tick
    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        unit_sub_next   = unit_sub_reg;
        unit_count_next = unit_count_reg;
        res_next        = '0;
        res_next.status = STATUS_OK;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start_req)
                begin
                    res_next.trig     = 1'b1;
                    res_next.busy_res = 1'b1;
                    if (20'd1 >= {12'd0, trigger_width_reg})
                    begin
                        phase_next      = PH_WAIT;
                        tick_count_next = 20'd0;
                    end
                    else
                    begin
                        phase_next      = PH_TRIG;
                        tick_count_next = 20'd1;
                    end
                end
            end
            PH_TRIG:
            begin
                res_next.trig     = 1'b1;
                res_next.busy_res = 1'b1;
                if (tick_inc >= {12'd0, trigger_width_reg})
                begin
                    phase_next      = PH_WAIT;
                    tick_count_next = 20'd0;
                end
                else
                begin
                    tick_count_next = tick_inc;
                end
            end
            PH_WAIT:
            begin
                if (echo)
                begin
                    res_next.busy_res = 1'b1;
                    phase_next        = PH_MEAS;
                    unit_sub_next     = 8'd0;
                    unit_count_next   = 16'd0;
                end
                else if (tick_inc >= response_timeout_reg)
                begin
                    res_next.done_res = 1'b1;
                    res_next.status   = STATUS_NO_RESPONSE;
                    phase_next        = PH_IDLE;
                    tick_count_next   = 20'd0;
                end
                else
                begin
                    res_next.busy_res = 1'b1;
                    tick_count_next   = tick_inc;
                end
            end
            PH_MEAS:
            begin
                res_next.busy_res = 1'b1;
                if (sub_inc >= unit_ticks_reg)
                begin
                    unit_sub_next   = 8'd0;
                    unit_count_next = count_inc;
                    if (count_inc >= range_limit_reg)
                    begin
                        res_next.busy_res = 1'b0;
                        res_next.done_res = 1'b1;
                        res_next.status   = STATUS_OUT_OF_RANGE;
                        phase_next        = PH_IDLE;
                    end
                    else if (!echo)
                    begin
                        res_next.busy_res = 1'b0;
                        res_next.done_res = 1'b1;
                        res_next.status   = STATUS_OK;
                        res_next.distance = dist_sum[17:1];
                        phase_next        = PH_IDLE;
                    end
                end
                else
                begin
                    unit_sub_next = sub_inc;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Hold measurement state; update only on an accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= 20'd0;
            unit_sub_reg   <= 8'd0;
            unit_count_reg <= 16'd0;
        end
        else if (in_accept)
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            unit_sub_reg   <= unit_sub_next;
            unit_count_reg <= unit_count_next;
        end
    end

    // Output buffer: main register plus skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_accept || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_accept;
            end
        end
        else if (in_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_accept || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_accept)
            begin
                out_reg <= res_next;
            end
        end
        else if (in_accept)
        begin
            skid_reg <= res_next;
        end
    end

    // Drive result ports
    assign out_valid = out_valid_reg;
    assign trig      = out_reg.trig;
    assign busy_res  = out_reg.busy_res;
    assign done_res  = out_reg.done_res;
    assign status    = out_reg.status;
    assign distance  = out_reg.distance;

endmodule

`default_nettype wire

// ===== design/uer_checker.sv =====
// Port-level checker for the echo ranger, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module uer_checker
    import uer_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        trig,
    input wire logic        busy_res,
    input wire logic        done_res,
    input wire logic [1:0]  status,
    input wire logic [16:0] distance
);

    // A stalled result stays put
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(distance) && $stable(status))

    // Input backs up only behind a waiting result
    `ASSERT_IMPLY(a_stall_needs_out, clk, rst_n, in_stall, out_valid)

    // A finishing tick is never busy and never drives the trigger
    `ASSERT_IMPLY(a_done_idle, clk, rst_n, out_valid && done_res, !busy_res && !trig)

    // Status and distance are clear unless a measurement finishes
    `ASSERT_IMPLY(a_quiet_fields, clk, rst_n, out_valid && !done_res, status == STATUS_OK && distance == 17'd0)

    // Distance is reported only with an ok status
    `ASSERT_IMPLY(a_dist_ok, clk, rst_n, out_valid && done_res && status != STATUS_OK, distance == 17'd0)

endmodule

bind ultrasonic_echo_ranger_unit uer_checker u_uer_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .trig      (trig),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .status    (status),
    .distance  (distance)
);

`default_nettype wire

// ===== tb/tb_ultrasonic_echo_ranger_unit.sv =====
// Self-checking testbench for the ultrasonic echo ranger unit.
`timescale 1ns / 100ps

module tb_ultrasonic_echo_ranger_unit;
    import uer_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned IDLE_PCT = 31;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned REPORT_CAP = 100;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [31:0] value;
        logic        start;
        logic        echo_lvl;
        logic        typed;
        result_t     want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        start_req;
    logic        echo;
    logic        out_valid;
    logic        out_stall;
    logic        trig;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [16:0] distance;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Ranging model state and register copies
    phase_t      ranger_phase;
    logic [19:0] tick_cnt;
    logic [7:0]  unit_sub;
    logic [15:0] unit_cnt;
    logic [7:0]  cfg_trigger_width;
    logic [19:0] cfg_response_timeout;
    logic [7:0]  cfg_unit_ticks;
    logic [15:0] cfg_range_limit;

    result_t     expected_echo_results[$];
    stim_row_t   directed_rows[$];

    int unsigned ticks_sent;
    int unsigned results_checked;
    int unsigned fail_count;
    int unsigned mismatch_reports;
    int unsigned ok_count;
    int unsigned no_response_count;
    int unsigned out_of_range_count;
    int unsigned hold_requests;
    bit          no_gaps;

    ultrasonic_echo_ranger_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .start_req (start_req),
        .echo      (echo),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .trig      (trig),
        .busy_res  (busy_res),
        .done_res  (done_res),
        .status    (status),
        .distance  (distance),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic result_t mk_result(logic t, logic b, logic d, logic [1:0] s,
                                          logic [16:0] dist_val);
        result_t r;
        r.trig = t;
        r.busy_res = b;
        r.done_res = d;
        r.status = s;
        r.distance = dist_val;
        return r;
    endfunction

    function automatic stim_row_t tick_row(logic s, logic e);
        stim_row_t row;
        row.kind = ROW_TICK;
        row.reg_idx = REG_TRIGGER_WIDTH;
        row.value = '0;
        row.start = s;
        row.echo_lvl = e;
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic stim_row_t typed_row(logic s, logic e, result_t w);
        stim_row_t row;
        row = tick_row(s, e);
        row.typed = 1'b1;
        row.want = w;
        return row;
    endfunction

    function automatic stim_row_t write_row(logic [1:0] idx, logic [31:0] v);
        stim_row_t row;
        row = tick_row(1'b0, 1'b0);
        row.kind = ROW_WRITE;
        row.reg_idx = idx;
        row.value = v;
        return row;
    endfunction

    // Load register copies from a write, keeping only the register's width
    function automatic void apply_register(logic [1:0] idx, logic [31:0] v);
        case (idx)
            REG_TRIGGER_WIDTH:    cfg_trigger_width = v[7:0];
            REG_RESPONSE_TIMEOUT: cfg_response_timeout = v[19:0];
            REG_UNIT_TICKS:       cfg_unit_ticks = v[7:0];
            default:              cfg_range_limit = v[15:0];
        endcase
    endfunction

    // Advance the ranging model by one tick and return the result it yields
    function automatic result_t predict_echo_tick(logic s, logic e);
        result_t     r;
        logic [17:0] triple;
        r = '0;
        case (ranger_phase)
            PH_IDLE:
            begin
                if (s)
                begin
                    r.trig = 1'b1;
                    r.busy_res = 1'b1;
                    tick_cnt = 20'd1;
                    if (tick_cnt >= 20'(cfg_trigger_width))
                    begin
                        ranger_phase = PH_WAIT;
                        tick_cnt = '0;
                    end
                    else
                    begin
                        ranger_phase = PH_TRIG;
                    end
                end
            end
            PH_TRIG:
            begin
                r.trig = 1'b1;
                r.busy_res = 1'b1;
                tick_cnt = tick_cnt + 20'd1;
                if (tick_cnt >= 20'(cfg_trigger_width))
                begin
                    ranger_phase = PH_WAIT;
                    tick_cnt = '0;
                end
            end
            PH_WAIT:
            begin
                if (e)
                begin
                    r.busy_res = 1'b1;
                    ranger_phase = PH_MEAS;
                    unit_sub = '0;
                    unit_cnt = '0;
                end
                else
                begin
                    tick_cnt = tick_cnt + 20'd1;
                    if (tick_cnt >= cfg_response_timeout)
                    begin
                        r.done_res = 1'b1;
                        r.status = STATUS_NO_RESPONSE;
                        ranger_phase = PH_IDLE;
                        tick_cnt = '0;
                    end
                    else
                    begin
                        r.busy_res = 1'b1;
                    end
                end
            end
            default:
            begin
                r.busy_res = 1'b1;
                unit_sub = unit_sub + 8'd1;
                if (unit_sub >= cfg_unit_ticks)
                begin
                    unit_sub = '0;
                    unit_cnt = unit_cnt + 16'd1;
                    // out of range wins over a falling echo
                    if (unit_cnt >= cfg_range_limit)
                    begin
                        r.busy_res = 1'b0;
                        r.done_res = 1'b1;
                        r.status = STATUS_OUT_OF_RANGE;
                        ranger_phase = PH_IDLE;
                    end
                    else if (!e)
                    begin
                        triple = 18'(unit_cnt) * 18'd3;
                        r.busy_res = 1'b0;
                        r.done_res = 1'b1;
                        r.status = STATUS_OK;
                        r.distance = triple[17:1];
                        ranger_phase = PH_IDLE;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Offer one tick, hold it until accepted, then queue its expected result
    task automatic send_tick(input logic s, input logic e, input logic use_want,
                             input result_t want);
        if (!no_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid <= 1'b1;
        start_req <= s;
        echo <= e;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (use_want)
        begin
            void'(predict_echo_tick(s, e));
            expected_echo_results.push_back(want);
        end
        else
        begin
            expected_echo_results.push_back(predict_echo_tick(s, e));
        end
        ticks_sent++;
    endtask

    // Drop valid and wait until every queued result has come back
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_echo_results.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Setup and access phases, then an idle phase with the bus released
    task automatic write_register(input logic [1:0] idx, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        apply_register(idx, v);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reconfigure(input logic [31:0] tw, input logic [31:0] rto,
                               input logic [31:0] ut, input logic [31:0] rl);
        wait_drain();
        write_register(REG_TRIGGER_WIDTH, tw);
        write_register(REG_RESPONSE_TIMEOUT, rto);
        write_register(REG_UNIT_TICKS, ut);
        write_register(REG_RANGE_LIMIT, rl);
    endtask

    // Drive whole measurements steered by the model's phase, some with glitches
    task automatic run_shots(input int unsigned budget, input int unsigned wait_cap,
                             input int unsigned pulse_cap);
        int unsigned sent_at_start;
        int unsigned wait_len;
        int unsigned pulse_len;
        int unsigned k;
        bit          noisy;
        logic        e;
        sent_at_start = ticks_sent;
        while (ticks_sent - sent_at_start < budget)
        begin
            noisy = ($urandom_range(99) < 20);
            wait_len = $urandom_range(0, wait_cap);
            pulse_len = $urandom_range(1, pulse_cap);
            send_tick(1'b1, 1'($urandom_range(1)), 1'b0, '0);
            while (ranger_phase == PH_TRIG)
                send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
            k = 0;
            while (ranger_phase == PH_WAIT)
            begin
                e = (k >= wait_len) || (noisy && $urandom_range(99) < 10);
                send_tick(1'($urandom_range(1)), e, 1'b0, '0);
                k++;
            end
            k = 0;
            while (ranger_phase == PH_MEAS)
            begin
                e = (k < pulse_len);
                if (noisy && $urandom_range(99) < 15)
                    e = ~e;
                send_tick(1'($urandom_range(1)), e, 1'b0, '0);
                k++;
            end
            // stray ticks between measurements, now and then a start
            repeat ($urandom_range(0, 3))
                send_tick(1'($urandom_range(99) < 10), 1'($urandom_range(1)), 1'b0, '0);
        end
    endtask

    // Result receiver: random stalls, plus long hold-offs on request
    initial
    begin : result_receiver
        int unsigned hold_left;
        int unsigned hold_served;
        hold_left = 0;
        hold_served = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Compare each result transaction with the oldest expectation
    initial
    begin : result_checker
        result_t want;
        bit      bad;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (expected_echo_results.size() == 0)
                begin
                    fail_count++;
                    if (mismatch_reports < REPORT_CAP)
                        $error("result transaction with no tick pending");
                    mismatch_reports++;
                end
                else
                begin
                    want = expected_echo_results.pop_front();
                    results_checked++;
                    bad = (want.trig !== trig) || (want.busy_res !== busy_res) ||
                          (want.done_res !== done_res) || (want.status !== status) ||
                          (want.distance !== distance);
                    if (bad)
                    begin
                        fail_count++;
                        if (mismatch_reports < REPORT_CAP)
                        begin
                            if (want.trig !== trig)
                                $error("trig: expected %0d, got %0d", want.trig, trig);
                            if (want.busy_res !== busy_res)
                                $error("busy_res: expected %0d, got %0d",
                                       want.busy_res, busy_res);
                            if (want.done_res !== done_res)
                                $error("done_res: expected %0d, got %0d",
                                       want.done_res, done_res);
                            if (want.status !== status)
                                $error("status: expected %0d, got %0d", want.status, status);
                            if (want.distance !== distance)
                                $error("distance: expected %0d, got %0d",
                                       want.distance, distance);
                        end
                        mismatch_reports++;
                    end
                    else if (done_res)
                    begin
                        case (status)
                            STATUS_OK:          ok_count++;
                            STATUS_NO_RESPONSE: no_response_count++;
                            default:            out_of_range_count++;
                        endcase
                    end
                end
            end
        end
    end

    // Watchdog on total run length
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_ultrasonic_echo_ranger_unit: FAIL");
        $finish;
    end

    // Main sequence
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        start_req = 1'b0;
        echo = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        ticks_sent = 0;
        results_checked = 0;
        fail_count = 0;
        mismatch_reports = 0;
        ok_count = 0;
        no_response_count = 0;
        out_of_range_count = 0;
        hold_requests = 0;
        no_gaps = 1'b0;

        ranger_phase = PH_IDLE;
        tick_cnt = '0;
        unit_sub = '0;
        unit_cnt = '0;
        cfg_trigger_width = TRIGGER_WIDTH_RST;
        cfg_response_timeout = RESPONSE_TIMEOUT_RST;
        cfg_unit_ticks = UNIT_TICKS_RST;
        cfg_range_limit = RANGE_LIMIT_RST;

        // Directed table: idle after reset, then short settings, then zeros
        directed_rows.push_back(typed_row(1'b0, 1'b0, '0));
        directed_rows.push_back(write_row(REG_TRIGGER_WIDTH, 32'd2));
        directed_rows.push_back(write_row(REG_RESPONSE_TIMEOUT, 32'd3));
        directed_rows.push_back(write_row(REG_UNIT_TICKS, 32'd2));
        directed_rows.push_back(write_row(REG_RANGE_LIMIT, 32'd3));
        // start tick, then a timeout; a start on the finishing tick is ignored
        directed_rows.push_back(typed_row(1'b1, 1'b0,
                                          mk_result(1'b1, 1'b1, 1'b0, STATUS_OK, 17'd0)));
        directed_rows.push_back(tick_row(1'b1, 1'b1));
        directed_rows.push_back(tick_row(1'b0, 1'b0));
        directed_rows.push_back(tick_row(1'b0, 1'b0));
        directed_rows.push_back(typed_row(1'b1, 1'b0,
                                          mk_result(1'b0, 1'b0, 1'b1, STATUS_NO_RESPONSE,
                                                    17'd0)));
        // echo held up to the range limit, low at the last unit end
        directed_rows.push_back(tick_row(1'b1, 1'b1));
        directed_rows.push_back(tick_row(1'b0, 1'b0));
        directed_rows.push_back(tick_row(1'b0, 1'b1));
        directed_rows.push_back(tick_row(1'b1, 1'b1));
        directed_rows.push_back(tick_row(1'b0, 1'b1));
        directed_rows.push_back(tick_row(1'b0, 1'b1));
        directed_rows.push_back(tick_row(1'b0, 1'b1));
        directed_rows.push_back(tick_row(1'b0, 1'b1));
        directed_rows.push_back(typed_row(1'b0, 1'b0,
                                          mk_result(1'b0, 1'b0, 1'b1, STATUS_OUT_OF_RANGE,
                                                    17'd0)));
        // one unit then echo low: ok, distance 1
        directed_rows.push_back(tick_row(1'b1, 1'b0));
        directed_rows.push_back(tick_row(1'b0, 1'b0));
        directed_rows.push_back(tick_row(1'b0, 1'b1));
        directed_rows.push_back(tick_row(1'b0, 1'b1));
        directed_rows.push_back(typed_row(1'b0, 1'b0,
                                          mk_result(1'b0, 1'b0, 1'b1, STATUS_OK, 17'd1)));
        // zero registers behave as one
        directed_rows.push_back(write_row(REG_TRIGGER_WIDTH, 32'd0));
        directed_rows.push_back(write_row(REG_RESPONSE_TIMEOUT, 32'd0));
        directed_rows.push_back(write_row(REG_UNIT_TICKS, 32'd0));
        directed_rows.push_back(write_row(REG_RANGE_LIMIT, 32'd0));
        directed_rows.push_back(typed_row(1'b1, 1'b1,
                                          mk_result(1'b1, 1'b1, 1'b0, STATUS_OK, 17'd0)));
        directed_rows.push_back(typed_row(1'b0, 1'b0,
                                          mk_result(1'b0, 1'b0, 1'b1, STATUS_NO_RESPONSE,
                                                    17'd0)));
        directed_rows.push_back(tick_row(1'b1, 1'b0));
        directed_rows.push_back(tick_row(1'b0, 1'b1));
        directed_rows.push_back(typed_row(1'b0, 1'b0,
                                          mk_result(1'b0, 1'b0, 1'b1, STATUS_OUT_OF_RANGE,
                                                    17'd0)));

        // Hold reset, release on a rising edge
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                wait_drain();
                write_register(directed_rows[i].reg_idx, directed_rows[i].value);
            end
            else
            begin
                send_tick(directed_rows[i].start, directed_rows[i].echo_lvl,
                          directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Short settings with no idling on either side
        reconfigure($urandom_range(1, 4), $urandom_range(4, 40), $urandom_range(1, 4),
                    $urandom_range(2, 20));
        no_gaps = 1'b1;
        run_shots(350, 50, 90);
        no_gaps = 1'b0;

        // Widest trigger, longest timeout, single-tick units, widest range
        reconfigure(32'd255, 32'd1048575, 32'd1, 32'd65535);
        run_shots(300, 60, 400);

        // Shortest trigger and timeout, longest units, one-unit range
        reconfigure(32'd1, 32'd1, 32'd255, 32'd1);
        run_shots(300, 2, 300);

        // Receiver holds off while ticks keep coming
        reconfigure($urandom_range(1, 6), $urandom_range(2, 30), $urandom_range(1, 5),
                    $urandom_range(1, 15));
        hold_requests++;
        run_shots(300, 35, 80);

        // Zero fields with junk in the unused upper bits
        reconfigure({16'($urandom_range(16'hFFFF)), 8'h00, 8'h00},
                    {12'($urandom_range(12'hFFF)), 20'h00000},
                    {16'($urandom_range(16'hFFFF)), 8'h00, 8'h00},
                    {16'($urandom_range(16'hFFFF)), 16'h0000});
        run_shots(200, 3, 6);

        reconfigure($urandom_range(0, 8), $urandom_range(1, 25), $urandom_range(0, 6),
                    $urandom_range(1, 12));
        run_shots(300, 30, 70);

        // Let the last results arrive, then idle and check that none is still expected
        wait_drain();
        repeat (8) @(posedge clk);
        if (expected_echo_results.size() != 0)
        begin
            fail_count++;
            $error("%0d expected results never arrived", expected_echo_results.size());
        end

        $display("Sent %0d ticks, checked %0d results over the reset, directed and six random register settings.",
                 ticks_sent, results_checked);
        $display("Finished measurements: %0d ok, %0d no response, %0d out of range.",
                 ok_count, no_response_count, out_of_range_count);
        if (fail_count == 0)
            $display("tb_ultrasonic_echo_ranger_unit: PASS");
        else
            $display("tb_ultrasonic_echo_ranger_unit: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/uer_pkg.sv
design/ultrasonic_echo_ranger_unit.sv
design/uer_checker.sv
tb/tb_ultrasonic_echo_ranger_unit.sv
